FILE: hdl/cbot_pkg.sv
`timescale 1ns / 1ps

package cbot_pkg;

    localparam int TABLE_CARDS       = 4096;
    localparam int CARD_WORDS        = 64;
    localparam int REGION_POWERS     = 4;
    localparam int BACKSKIP_LOG_BASE = 3;

    localparam int CARD_BITS   = $clog2(TABLE_CARDS);
    localparam int HEAP_WORDS  = TABLE_CARDS * CARD_WORDS;
    localparam int WORD_BITS   = 18;
    localparam int END_BITS    = 19;
    localparam int ENTRY_BITS  = 8;
    localparam int REGION_BITS = (REGION_POWERS > 1) ? $clog2(REGION_POWERS) : 1;
    // smallest backskip power whose span reaches past every card index
    localparam int SKIP_POW_LIMIT = (CARD_BITS + BACKSKIP_LOG_BASE - 1) / BACKSKIP_LOG_BASE;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_INVALID    = 2'd1;
    localparam logic [1:0] STATUS_BELOW_ZERO = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [WORD_BITS-1:0] block_start_word;
        logic [END_BITS-1:0]  block_end_word;
        logic [WORD_BITS-1:0] query_word;
    } cbot_in_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] found_start;
        logic [1:0]           status;
    } cbot_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RECORD,
        S_READ,
        S_EVAL,
        S_DONE
    } cbot_state_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_LOAD,
        OP_FILL,
        OP_EVAL
    } cbot_op_t;

    typedef struct packed {
        cbot_op_t op;
        logic     res_load;
    } cbot_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic load_query;
        logic load_bad;
        logic fill_last;
        logic entry_skip;
        logic skip_fail;
    } cbot_stat_t;

    // region of a card lying gap cards past the offset card
    function automatic logic [REGION_BITS-1:0] region_of(input logic [CARD_BITS-1:0] gap);
        logic [REGION_BITS-1:0] r;
        r = '0;
        for (int i = 1; i < REGION_POWERS; i++)
        begin
            if ((BACKSKIP_LOG_BASE * i < CARD_BITS) &&
                ((gap >> (BACKSKIP_LOG_BASE * i)) != '0))
            begin
                r = REGION_BITS'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/cbot_ram.sv
`timescale 1ns / 1ps

module cbot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/cbot_ctrl.sv
`timescale 1ns / 1ps

module cbot_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  logic                result_stall,
    input  cbot_pkg::cbot_stat_t stat,
    output cbot_pkg::cbot_cmd_t  cmd
);

    cbot_pkg::cbot_state_t state_reg, state_next;
    logic                  valid_reg, valid_next;
    logic                  slot_free;

    assign slot_free = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbot_pkg::S_CLEAR;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbot_pkg::S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = cbot_pkg::S_IDLE;
                end
            end
            cbot_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    priority if (stat.load_bad)
                    begin
                        state_next = cbot_pkg::S_DONE;
                    end
                    else if (stat.load_query)
                    begin
                        state_next = cbot_pkg::S_READ;
                    end
                    else
                    begin
                        state_next = cbot_pkg::S_RECORD;
                    end
                end
            end
            cbot_pkg::S_RECORD:
            begin
                if (stat.fill_last)
                begin
                    state_next = cbot_pkg::S_DONE;
                end
            end
            cbot_pkg::S_READ:
            begin
                state_next = cbot_pkg::S_EVAL;
            end
            cbot_pkg::S_EVAL:
            begin
                if (stat.entry_skip && !stat.skip_fail)
                begin
                    state_next = cbot_pkg::S_READ;
                end
                else
                begin
                    state_next = cbot_pkg::S_DONE;
                end
            end
            cbot_pkg::S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = cbot_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cbot_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd.op       = cbot_pkg::OP_IDLE;
        cmd.res_load = 1'b0;
        item_stall   = 1'b1;
        unique case (state_reg)
            cbot_pkg::S_CLEAR:
            begin
                cmd.op = cbot_pkg::OP_CLEAR;
            end
            cbot_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.op = cbot_pkg::OP_LOAD;
                end
            end
            cbot_pkg::S_RECORD:
            begin
                cmd.op = cbot_pkg::OP_FILL;
            end
            cbot_pkg::S_READ:
            begin
                cmd.op = cbot_pkg::OP_IDLE;
            end
            cbot_pkg::S_EVAL:
            begin
                cmd.op = cbot_pkg::OP_EVAL;
            end
            cbot_pkg::S_DONE:
            begin
                cmd.res_load = slot_free;
            end
            default:
            begin
                cmd.op = cbot_pkg::OP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.res_load)
        begin
            valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    assign result_valid = valid_reg;

endmodule

FILE: hdl/cbot_datapath.sv
`timescale 1ns / 1ps

module cbot_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbot_pkg::cbot_in_t   item,
    input  cbot_pkg::cbot_cmd_t  cmd,
    output cbot_pkg::cbot_stat_t stat,
    output cbot_pkg::cbot_out_t  result
);

    localparam int CB = cbot_pkg::CARD_BITS;
    localparam int WB = cbot_pkg::WORD_BITS;
    localparam int EB = cbot_pkg::END_BITS;
    localparam int NB = cbot_pkg::ENTRY_BITS;

    logic [CB-1:0] card_reg, card_next;
    logic [CB-1:0] anchor_card_reg;
    logic [CB-1:0] last_card_reg;
    logic [NB-1:0] offset_val_reg;
    logic [WB-1:0] found_reg;
    logic [1:0]    status_reg;
    cbot_pkg::cbot_out_t out_reg;

    // load-time checks
    logic [EB-1:0] start_ext;
    logic [EB-1:0] boundary;
    logic [EB-1:0] end_minus1;
    logic          rec_bad;
    logic          query_bad;
    logic [CB-1:0] load_card;
    logic [CB-1:0] load_anchor_card;
    logic [CB-1:0] load_last_card;
    logic [NB-1:0] load_offset_val;

    // fill
    logic [CB-1:0] card_gap;
    logic [NB-1:0] fill_data;

    // walk
    logic [NB-1:0] entry;
    logic [NB-1:0] skip_pow;
    logic          skip_far;
    logic [CB-1:0] back;
    logic [WB-1:0] base;
    logic          entry_skip;
    logic          skip_fail;
    logic          below_zero;

    logic          ram_we;
    logic [NB-1:0] ram_wdata;
    logic [NB-1:0] ram_rdata_w;

    always_comb
    begin
        start_ext  = EB'(item.block_start_word);
        boundary   = ((start_ext + EB'(cbot_pkg::CARD_WORDS - 1)) / EB'(cbot_pkg::CARD_WORDS))
                     * EB'(cbot_pkg::CARD_WORDS);
        end_minus1 = item.block_end_word - EB'(1);
        rec_bad    = (item.block_end_word > EB'(cbot_pkg::HEAP_WORDS)) ||
                     (item.block_end_word <= boundary);
        query_bad  = EB'(item.query_word) >= EB'(cbot_pkg::HEAP_WORDS);
        load_card        = CB'(item.query_word / cbot_pkg::CARD_WORDS);
        load_anchor_card = CB'(boundary / cbot_pkg::CARD_WORDS);
        load_last_card   = CB'(end_minus1 / cbot_pkg::CARD_WORDS);
        load_offset_val  = NB'(boundary - start_ext);
    end

    always_comb
    begin
        card_gap = card_reg - anchor_card_reg;
        if (card_gap == '0)
        begin
            fill_data = offset_val_reg;
        end
        else
        begin
            fill_data = NB'(cbot_pkg::CARD_WORDS) + NB'(cbot_pkg::region_of(card_gap));
        end
    end

    always_comb
    begin
        entry      = ram_rdata_w;
        entry_skip = entry >= NB'(cbot_pkg::CARD_WORDS);
        skip_pow   = entry - NB'(cbot_pkg::CARD_WORDS);
        skip_far   = skip_pow >= NB'(cbot_pkg::SKIP_POW_LIMIT);
        if (skip_far)
        begin
            back = '0;
        end
        else
        begin
            back = CB'(1) << (32'(skip_pow) * cbot_pkg::BACKSKIP_LOG_BASE);
        end
        skip_fail  = skip_far || (back > card_reg);
        base       = WB'(card_reg) * WB'(cbot_pkg::CARD_WORDS);
        below_zero = WB'(entry) > base;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        unique case (cmd.op)
            cbot_pkg::OP_CLEAR:
            begin
                ram_we = 1'b1;
            end
            cbot_pkg::OP_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = fill_data;
            end
            cbot_pkg::OP_IDLE,
            cbot_pkg::OP_LOAD,
            cbot_pkg::OP_EVAL:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    cbot_ram #(
        .WIDTH (NB),
        .DEPTH (cbot_pkg::TABLE_CARDS)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (card_reg),
        .wdata (ram_wdata),
        .raddr (card_reg),
        .rdata (ram_rdata_w)
    );

    always_comb
    begin
        card_next = card_reg;
        unique case (cmd.op)
            cbot_pkg::OP_CLEAR,
            cbot_pkg::OP_FILL:
            begin
                card_next = card_reg + CB'(1);
            end
            cbot_pkg::OP_LOAD:
            begin
                card_next = (item.command == cbot_pkg::CMD_QUERY) ? load_card : load_anchor_card;
            end
            cbot_pkg::OP_EVAL:
            begin
                if (entry_skip && !skip_fail)
                begin
                    card_next = card_reg - back;
                end
            end
            cbot_pkg::OP_IDLE:
            begin
                card_next = card_reg;
            end
            default:
            begin
                card_next = card_reg;
            end
        endcase
    end

    // card index doubles as the clearing sweep pointer, so it starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_reg <= '0;
        end
        else
        begin
            card_reg <= card_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == cbot_pkg::OP_LOAD)
        begin
            anchor_card_reg <= load_anchor_card;
            last_card_reg   <= load_last_card;
            offset_val_reg  <= load_offset_val;
            found_reg       <= '0;
            if (item.command == cbot_pkg::CMD_QUERY)
            begin
                status_reg <= query_bad ? cbot_pkg::STATUS_INVALID : cbot_pkg::STATUS_OK;
            end
            else
            begin
                status_reg <= rec_bad ? cbot_pkg::STATUS_INVALID : cbot_pkg::STATUS_OK;
            end
        end
        else if (cmd.op == cbot_pkg::OP_EVAL)
        begin
            priority if (entry_skip)
            begin
                if (skip_fail)
                begin
                    status_reg <= cbot_pkg::STATUS_BELOW_ZERO;
                    found_reg  <= '0;
                end
            end
            else if (below_zero)
            begin
                status_reg <= cbot_pkg::STATUS_BELOW_ZERO;
                found_reg  <= '0;
            end
            else
            begin
                status_reg <= cbot_pkg::STATUS_OK;
                found_reg  <= base - WB'(entry);
            end
        end

        if (cmd.res_load)
        begin
            out_reg.found_start <= found_reg;
            out_reg.status      <= status_reg;
        end
    end

    always_comb
    begin
        stat.clear_last = card_reg == CB'(cbot_pkg::TABLE_CARDS - 1);
        stat.load_query = item.command == cbot_pkg::CMD_QUERY;
        stat.load_bad   = (item.command == cbot_pkg::CMD_QUERY) ? query_bad : rec_bad;
        stat.fill_last  = card_reg == last_card_reg;
        stat.entry_skip = entry_skip;
        stat.skip_fail  = skip_fail;
    end

    assign result = out_reg;

endmodule

FILE: hdl/card_block_offset_table.sv
`timescale 1ns / 1ps

// Channel   Handshake              Beat
// item      item_valid/item_stall  cbot_in_t: command, block start/end, query word
// result    result_valid/result_stall  cbot_out_t: found_start, status
//
// After reset the card table is swept to zero, one card a cycle, with item_stall
// high. Record: after the load, entries are written from the offset card to the
// block's last card. Query: for each card visited, a read state waits on the
// registered read of the entry memory and an eval state follows the entry found.
// A rejected item goes from the load step straight to the done state.
// One item at a time; a finished beat waits in the output register while the
// next item is taken, and a result_stall held past that item's end stalls the input.

module card_block_offset_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  cbot_pkg::cbot_in_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output cbot_pkg::cbot_out_t result
);

    cbot_pkg::cbot_cmd_t  cmd;
    cbot_pkg::cbot_stat_t stat;

    cbot_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    cbot_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

FILE: test/cbot_checker.sv
`timescale 1ns / 1ps

module cbot_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  cbot_pkg::cbot_in_t  item,
    input  logic                result_valid,
    input  logic                result_stall,
    input  cbot_pkg::cbot_out_t result,
    output int                  fail_count,
    output int                  results_pending
);

    typedef struct packed {
        cbot_pkg::cbot_in_t  beat;
        cbot_pkg::cbot_out_t want;
    } due_result_t;

    localparam int NB = cbot_pkg::ENTRY_BITS;
    localparam int WB = cbot_pkg::WORD_BITS;
    localparam longint unsigned SPAN_SHIFT_CAP = 40;

    logic [NB-1:0] card_bytes [cbot_pkg::TABLE_CARDS];
    due_result_t   due_results [$];
    int            mismatches = 0;
    int            due_count  = 0;

    assign fail_count      = mismatches;
    assign results_pending = due_count;

    task automatic report_mismatch(input string what);
        // print the first few only, keep counting the rest
        if (mismatches < 40)
        begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    // cards covered by one backskip of power p, saturated past any card index
    function automatic longint unsigned skip_span(input longint unsigned p);
        longint unsigned sh;
        sh = cbot_pkg::BACKSKIP_LOG_BASE * p;
        if (sh >= SPAN_SHIFT_CAP)
        begin
            return 64'd1 << SPAN_SHIFT_CAP;
        end
        return 64'd1 << sh;
    endfunction

    function automatic logic [1:0] note_block(input longint unsigned s,
                                              input longint unsigned e);
        longint unsigned boundary;
        longint unsigned anchor_card;
        longint unsigned tail_card;
        longint unsigned first;
        longint unsigned reach;
        longint unsigned last;
        boundary = ((s + cbot_pkg::CARD_WORDS - 1) / cbot_pkg::CARD_WORDS)
                   * cbot_pkg::CARD_WORDS;
        if (e > cbot_pkg::HEAP_WORDS || e <= boundary)
        begin
            return cbot_pkg::STATUS_INVALID;
        end
        anchor_card = boundary / cbot_pkg::CARD_WORDS;
        tail_card   = (e - 1) / cbot_pkg::CARD_WORDS;
        card_bytes[anchor_card] = NB'(boundary - s);
        first = anchor_card + 1;
        for (int r = 0; r < cbot_pkg::REGION_POWERS && first <= tail_card; r++)
        begin
            reach = anchor_card + skip_span(r + 1) - 1;
            last  = (reach < tail_card) ? reach : tail_card;
            // last region soaks up whatever is left of the block
            if (r == cbot_pkg::REGION_POWERS - 1)
            begin
                last = tail_card;
            end
            for (longint unsigned c = first; c <= last; c++)
            begin
                card_bytes[c] = NB'(cbot_pkg::CARD_WORDS + r);
            end
            first = last + 1;
        end
        return cbot_pkg::STATUS_OK;
    endfunction

    function automatic logic [1:0] locate_start(input  longint unsigned q,
                                                output logic [WB-1:0] found);
        longint unsigned card;
        longint unsigned entry;
        longint unsigned span;
        longint unsigned base;
        found = '0;
        if (q >= cbot_pkg::HEAP_WORDS)
        begin
            return cbot_pkg::STATUS_INVALID;
        end
        card  = q / cbot_pkg::CARD_WORDS;
        entry = card_bytes[card];
        while (entry >= cbot_pkg::CARD_WORDS)
        begin
            span = skip_span(entry - cbot_pkg::CARD_WORDS);
            if (span > card)
            begin
                return cbot_pkg::STATUS_BELOW_ZERO;
            end
            card  = card - span;
            entry = card_bytes[card];
        end
        base = card * cbot_pkg::CARD_WORDS;
        if (entry > base)
        begin
            return cbot_pkg::STATUS_BELOW_ZERO;
        end
        found = WB'(base - entry);
        return cbot_pkg::STATUS_OK;
    endfunction

    function automatic cbot_pkg::cbot_out_t table_response(input cbot_pkg::cbot_in_t beat);
        cbot_pkg::cbot_out_t r;
        r.found_start = '0;
        if (beat.command == cbot_pkg::CMD_RECORD)
        begin
            r.status = note_block(beat.block_start_word, beat.block_end_word);
        end
        else
        begin
            r.status = locate_start(beat.query_word, r.found_start);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        due_result_t head;
        if (!rst_n)
        begin
            for (int c = 0; c < cbot_pkg::TABLE_CARDS; c++)
            begin
                card_bytes[c] = '0;
            end
            due_results.delete();
            mismatches = 0;
        end
        else
        begin
            // a result beat can never belong to an item taken at the same edge
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result found_start %0d status %0d",
                                              result.found_start, result.status));
                end
                else
                begin
                    head = due_results.pop_front();
                    if (result.found_start !== head.want.found_start)
                    begin
                        report_mismatch($sformatf(
                            "found_start %0d, want %0d (cmd %0d s %0d e %0d q %0d)",
                            result.found_start, head.want.found_start, head.beat.command,
                            head.beat.block_start_word, head.beat.block_end_word,
                            head.beat.query_word));
                    end
                    if (result.status !== head.want.status)
                    begin
                        report_mismatch($sformatf(
                            "status %0d, want %0d (cmd %0d s %0d e %0d q %0d)",
                            result.status, head.want.status, head.beat.command,
                            head.beat.block_start_word, head.beat.block_end_word,
                            head.beat.query_word));
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                head.beat = item;
                head.want = table_response(item);
                due_results.push_back(head);
            end
        end
        due_count = due_results.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 170;
    localparam int SETTLE_WAIT  = 30;
    localparam int WB           = cbot_pkg::WORD_BITS;
    localparam int EB           = cbot_pkg::END_BITS;
    localparam int HEAP         = cbot_pkg::HEAP_WORDS;
    localparam int CW           = cbot_pkg::CARD_WORDS;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    cbot_pkg::cbot_in_t  item;
    logic                result_valid;
    logic                result_stall;
    cbot_pkg::cbot_out_t result;

    int fail_count;
    int results_pending;

    int idle_pct    = 0;
    int stall_pct   = 0;
    bit hold_req    = 1'b0;
    int beats_sent  = 0;
    int records     = 0;
    int queries     = 0;

    card_block_offset_table uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    cbot_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall, or one long hold-off on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    @(posedge clk);
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic cbot_pkg::cbot_in_t random_beat();
        cbot_pkg::cbot_in_t b;
        b.command          = 1'($urandom_range(1));
        b.block_start_word = WB'($urandom_range(HEAP - 1));
        b.block_end_word   = EB'($urandom_range(HEAP));
        b.query_word       = WB'($urandom_range(HEAP - 1));
        return b;
    endfunction

    task automatic push_item(input cbot_pkg::cbot_in_t beat);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic record_block(input int unsigned s, input int unsigned e);
        cbot_pkg::cbot_in_t beat;
        beat                  = random_beat();
        beat.command          = cbot_pkg::CMD_RECORD;
        beat.block_start_word = WB'(s);
        beat.block_end_word   = EB'(e);
        push_item(beat);
        records++;
    endtask

    task automatic ask_start(input int unsigned q);
        cbot_pkg::cbot_in_t beat;
        beat            = random_beat();
        beat.command    = cbot_pkg::CMD_QUERY;
        beat.query_word = WB'(q);
        push_item(beat);
        queries++;
    endtask

    // sender goes quiet until every outstanding beat is back
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // a valid block of mostly few cards, then lookups inside it
    task automatic block_and_lookups();
        int unsigned cards;
        int unsigned len;
        int unsigned s;
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            cards = $urandom_range(1, 8);
        else if (pick < 95)
            cards = $urandom_range(9, 300);
        else
            cards = $urandom_range(301, cbot_pkg::TABLE_CARDS);
        len = cards * CW + $urandom_range(CW - 1);
        if (len > HEAP)
            len = HEAP;
        s = $urandom_range(HEAP - len);
        record_block(s, s + len);
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(3) == 0)
                ask_start(s + len - 1);
            else
                ask_start($urandom_range(s, s + len - 1));
        end
    endtask

    task automatic noise_beat();
        int unsigned s;
        if ($urandom_range(1) == 0)
        begin
            ask_start($urandom_range(HEAP - 1));
        end
        else
        begin
            s = $urandom_range(HEAP - 1);
            case ($urandom_range(9))
                0:       record_block(s, $urandom_range((1 << EB) - 1));
                1, 2, 3: record_block(s, $urandom_range(s, s + 2 * CW));
                default: record_block(s, $urandom_range(HEAP));
            endcase
        end
    endtask

    initial
    begin
        int phase_idle  [4];
        int phase_stall [4];
        int phase_end;
        phase_idle  = '{0, 59, 0, 20};
        phase_stall = '{0, 0, 59, 20};

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, whole-table blocks, rejected blocks
        ask_start(0);
        ask_start(HEAP - 1);
        record_block(0, HEAP);
        ask_start(HEAP - 1);
        ask_start(9 * CW + 3);
        ask_start(70 * CW);
        ask_start(600 * CW + 17);
        record_block(HEAP - 1, HEAP);
        record_block(65, 128);
        record_block(65, 129);
        ask_start(150);
        record_block(0, 0);
        record_block(100, HEAP + 1);
        record_block(HEAP - 1, (1 << EB) - 1);
        record_block(1, HEAP);
        ask_start(HEAP - 1);
        ask_start(CW);
        ask_start(0);
        record_block(4000 * CW + 5, HEAP);
        ask_start(HEAP - 1);
        record_block(10 * CW, 11 * CW);
        ask_start(11 * CW - 1);
        ask_start((HEAP - 1) & 18'h2AAAA);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            phase_end = beats_sent + PHASE_ITEMS;
            if (ph == 2)
            begin
                // long hold-off while items keep coming, so the input backs up
                hold_req = 1'b1;
                idle_pct = 0;
                repeat (3) block_and_lookups();
                idle_pct = phase_idle[ph];
            end
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(99) < 75)
                    block_and_lookups();
                else
                    noise_beat();
            end
            // sender pause until every outstanding beat is back
            wait_drained();
        end

        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Summary: %0d beats (%0d block records, %0d start lookups)", beats_sent,
                 records, queries);
        $display("Summary: full-table and rejected blocks, four idle/stall mixes, long hold-off");
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
